[src/mfr_pkg.sv]
// Package for the meter frame receiver: item types, codes and constants.
// Used by mfr_front, mfr_back and meter_frame_receiver; depends on nothing.
`default_nettype none

package mfr_pkg;

  // Default for the data capacity of one frame, in bytes (1 to 8)
  localparam int unsigned MAX_DATA_BYTES_DEF = 8;

  // Frame delimiters and byte coding
  localparam logic [7:0] PREAMBLE_BYTE = 8'hFE;
  localparam logic [7:0] HEADER_BYTE   = 8'h68;
  localparam logic [7:0] TRAILER_BYTE  = 8'h16;
  localparam logic [7:0] CODE_OFFSET   = 8'h33;

  // Frame offsets counted from the header byte
  localparam logic [7:0] OFS_ADDR_FIRST = 8'd1;
  localparam logic [7:0] OFS_ADDR_LAST  = 8'd6;
  localparam logic [7:0] OFS_CONTROL    = 8'd8;
  localparam logic [7:0] OFS_LENGTH     = 8'd9;
  localparam logic [7:0] OFS_CMD_LO     = 8'd10;
  localparam logic [7:0] OFS_CMD_HI     = 8'd11;
  localparam logic [7:0] OFS_DATA       = 8'd12;
  localparam logic [7:0] OFS_TRAILER    = 8'd13;

  // Reset value of the timeout register
  localparam logic [31:0] TIMEOUT_RESET = 32'd1000;

  // Input opcodes
  typedef enum logic [1:0] {
    OP_RESTART = 2'd0,
    OP_BYTE    = 2'd1,
    OP_TICK    = 2'd2
  } opcode_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SUM_BAD  = 2'd1,
    ST_TIMEOUT  = 2'd2
  } status_e;

  // One input item
  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] rx_byte;
  } in_item_t;

  // One result item
  typedef struct packed {
    logic [1:0]  status;
    logic        from_master;
    logic [15:0] command_word;
    logic [3:0]  data_count;
    logic [63:0] data_bytes;
    logic [47:0] meter_address;
  } out_item_t;

  // Classified command passed from front to back
  typedef struct packed {
    opcode_e    op;
    logic [7:0] rx_byte;
  } cmd_t;

endpackage

`default_nettype wire

[src/mfr_front.sv]
// Front of the meter frame receiver: accepts items, drops unused opcodes and
// queues commands for the back. Depends on mfr_pkg.
`default_nettype none

module mfr_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire mfr_pkg::in_item_t in_item_i,
  output logic                  cmd_valid_o,
  output mfr_pkg::cmd_t         cmd_o,
  input  wire logic             cmd_pop_i
);

  localparam logic [1:0] QDepth = 2'd2;

  mfr_pkg::cmd_t q_mem_q [2];
  mfr_pkg::cmd_t q_mem_d [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       accept;
  logic       push;
  mfr_pkg::cmd_t cmd_new;

  // Stall only when the queue is full
  assign in_stall_o  = (count_q == QDepth);
  assign accept      = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = q_mem_q[rd_ptr_q];

  // Classify: keep restart, byte and tick; drop anything else
  always_comb begin
    cmd_new.op      = mfr_pkg::opcode_e'(in_item_i.opcode);
    cmd_new.rx_byte = in_item_i.rx_byte;
    case (in_item_i.opcode)
      mfr_pkg::OP_RESTART,
      mfr_pkg::OP_BYTE,
      mfr_pkg::OP_TICK: push = accept;
      default:          push = 1'b0;
    endcase
  end

  // Advance queue pointers and count
  always_comb begin
    q_mem_d  = q_mem_q;
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      q_mem_d[wr_ptr_q] = cmd_new;
      wr_ptr_d          = !wr_ptr_q;
    end
    if (cmd_pop_i) begin
      rd_ptr_d = !rd_ptr_q;
    end
    case ({push, cmd_pop_i})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage holds payload only
  always_ff @(posedge clk_i) begin
    q_mem_q <= q_mem_d;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QDepth)
    else $error("command queue over depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_i |-> count_q != 2'd0)
    else $error("pop from empty command queue");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd1) |-> (wr_ptr_q != rd_ptr_q))
    else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

[src/mfr_back.sv]
// Back of the meter frame receiver: frame state, timeout counter, timeout
// register and the output register. Depends on mfr_pkg.
`default_nettype none

module mfr_back #(
  parameter int unsigned MAX_DATA_BYTES = mfr_pkg::MAX_DATA_BYTES_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_valid_i,
  input  wire logic [31:0]       cfg_data_i,
  input  wire logic              cmd_valid_i,
  input  wire mfr_pkg::cmd_t     cmd_i,
  output logic                   cmd_pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output mfr_pkg::out_item_t     out_item_o
);

  localparam int unsigned DataW = MAX_DATA_BYTES * 8;
  localparam logic [7:0]  MaxB  = 8'(MAX_DATA_BYTES);
  localparam logic [3:0]  MaxN  = 4'(MAX_DATA_BYTES);

  typedef enum logic [1:0] {
    PH_HUNT     = 2'd0,
    PH_WAIT_HDR = 2'd1,
    PH_FRAME    = 2'd2
  } phase_e;

  phase_e             phase_q, phase_d;
  logic [7:0]         offset_q, offset_d;
  logic [7:0]         sum_q, sum_d;
  logic               matched_q, matched_d;
  logic [47:0]        addr_q, addr_d;
  logic               dir_q, dir_d;
  logic [15:0]        cmd_word_q, cmd_word_d;
  logic [DataW-1:0]   data_q, data_d;
  logic [3:0]         plen_q, plen_d;
  logic [3:0]         ccount_q, ccount_d;
  logic [31:0]        elapsed_q, elapsed_d;
  logic [31:0]        timeout_q, timeout_d;
  logic               out_valid_q, out_valid_d;
  mfr_pkg::out_item_t out_item_q, out_item_d;

  logic               go;
  logic               emit;
  mfr_pkg::out_item_t result;
  logic [7:0]         b;
  logic [7:0]         dec;
  logic [7:0]         ofs;
  logic [7:0]         len_n;
  logic [31:0]        elapsed_inc;

  // Take a command when the output slot is free or draining
  assign go        = cmd_valid_i && (!out_valid_q || !out_stall_i);
  assign cmd_pop_o = go;
  assign b         = cmd_i.rx_byte;
  assign dec       = b - mfr_pkg::CODE_OFFSET;
  assign ofs       = (offset_q != 8'hFF) ? offset_q + 8'd1 : offset_q;
  assign len_n     = b - 8'd2;
  assign elapsed_inc = (elapsed_q != 32'hFFFF_FFFF) ? elapsed_q + 32'd1 : elapsed_q;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Frame state update and result build
  always_comb begin
    phase_d    = phase_q;
    offset_d   = offset_q;
    sum_d      = sum_q;
    matched_d  = matched_q;
    addr_d     = addr_q;
    dir_d      = dir_q;
    cmd_word_d = cmd_word_q;
    data_d     = data_q;
    plen_d     = plen_q;
    ccount_d   = ccount_q;
    elapsed_d  = elapsed_q;
    emit       = 1'b0;
    result     = '0;

    if (go) begin
      case (cmd_i.op)
        mfr_pkg::OP_RESTART: begin
          phase_d = PH_HUNT;
        end
        mfr_pkg::OP_TICK: begin
          elapsed_d = elapsed_inc;
          if (elapsed_inc > timeout_q) begin
            emit          = 1'b1;
            result.status = mfr_pkg::ST_TIMEOUT;
            phase_d       = PH_HUNT;
          end
        end
        mfr_pkg::OP_BYTE: begin
          case (phase_q)
            PH_HUNT: begin
              if (b == mfr_pkg::PREAMBLE_BYTE) begin
                phase_d = PH_WAIT_HDR;
              end
            end
            PH_WAIT_HDR: begin
              if (b == mfr_pkg::HEADER_BYTE) begin
                phase_d   = PH_FRAME;
                offset_d  = 8'd0;
                sum_d     = b;
                elapsed_d = 32'd0;
              end
            end
            default: begin
              offset_d = ofs;
              // Capture address, control, length and command bytes
              for (int i = 0; i < 6; i++) begin
                if (ofs == mfr_pkg::OFS_ADDR_FIRST + 8'(i)) begin
                  addr_d[i*8 +: 8] = b;
                end
              end
              if (ofs == mfr_pkg::OFS_CONTROL) begin
                dir_d = !b[7];
              end
              if (ofs == mfr_pkg::OFS_LENGTH) begin
                plen_d = (len_n > MaxB) ? MaxN : len_n[3:0];
              end
              if (ofs == mfr_pkg::OFS_CMD_LO) begin
                cmd_word_d[7:0] = dec;
              end
              if (ofs == mfr_pkg::OFS_CMD_HI) begin
                cmd_word_d[15:8] = dec;
              end
              // Store data bytes in arrival order
              if (ofs >= mfr_pkg::OFS_DATA && ccount_q < plen_q) begin
                for (int i = 0; i < MAX_DATA_BYTES; i++) begin
                  if (ccount_q == 4'(i)) begin
                    data_d[i*8 +: 8] = dec;
                  end
                end
                ccount_d = ccount_q + 4'd1;
              end
              // Check the checksum byte against the running sum
              if (ofs == mfr_pkg::OFS_DATA + {4'd0, plen_q}) begin
                matched_d = (sum_q == b);
              end
              // Close the frame on a good trailer
              if (ofs == mfr_pkg::OFS_TRAILER + {4'd0, plen_q} &&
                  b == mfr_pkg::TRAILER_BYTE) begin
                emit                = 1'b1;
                result.status       = matched_q ? mfr_pkg::ST_OK : mfr_pkg::ST_SUM_BAD;
                result.from_master  = dir_q;
                result.command_word = cmd_word_q;
                result.data_count   = plen_q;
                result.data_bytes   = 64'(data_q);
                result.meter_address = matched_q ? addr_q : 48'd0;
                phase_d             = PH_HUNT;
              end else begin
                sum_d = sum_q + b;
              end
            end
          endcase
        end
        default: begin
        end
      endcase

      // Rearm: clear all frame state
      if (phase_d == PH_HUNT && (cmd_i.op == mfr_pkg::OP_RESTART || emit)) begin
        offset_d   = 8'd0;
        sum_d      = 8'd0;
        matched_d  = 1'b0;
        addr_d     = 48'd0;
        dir_d      = 1'b0;
        cmd_word_d = 16'd0;
        data_d     = '0;
        plen_d     = 4'd0;
        ccount_d   = 4'd0;
        elapsed_d  = 32'd0;
      end
    end
  end

  // Output register and timeout register
  always_comb begin
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    timeout_d   = timeout_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
      out_item_d  = result;
    end
    if (cfg_valid_i) begin
      timeout_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HUNT;
      offset_q    <= 8'd0;
      sum_q       <= 8'd0;
      matched_q   <= 1'b0;
      addr_q      <= 48'd0;
      dir_q       <= 1'b0;
      cmd_word_q  <= 16'd0;
      data_q      <= '0;
      plen_q      <= 4'd0;
      ccount_q    <= 4'd0;
      elapsed_q   <= 32'd0;
      timeout_q   <= mfr_pkg::TIMEOUT_RESET;
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
    end else begin
      phase_q     <= phase_d;
      offset_q    <= offset_d;
      sum_q       <= sum_d;
      matched_q   <= matched_d;
      addr_q      <= addr_d;
      dir_q       <= dir_d;
      cmd_word_q  <= cmd_word_d;
      data_q      <= data_d;
      plen_q      <= plen_d;
      ccount_q    <= ccount_d;
      elapsed_q   <= elapsed_d;
      timeout_q   <= timeout_d;
      out_valid_q <= out_valid_d;
      out_item_q  <= out_item_d;
    end
  end

  a_pop_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> (!out_valid_q || !out_stall_i))
    else $error("command taken while output slot is blocked");

  a_capture_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ccount_q <= plen_q) && (plen_q <= MaxN))
    else $error("data capture beyond payload length");

  a_timeout_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_item_q.status == mfr_pkg::ST_TIMEOUT) |->
      (out_item_q.command_word == 16'd0 && out_item_q.data_bytes == 64'd0 &&
       out_item_q.meter_address == 48'd0 && !out_item_q.from_master))
    else $error("timeout result carries frame fields");

  a_addr_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_item_q.meter_address != 48'd0) |->
      out_item_q.status == mfr_pkg::ST_OK)
    else $error("address given on a failed frame");

endmodule

`default_nettype wire

[src/meter_frame_receiver.sv]
// Top level of the meter frame receiver: joins the front queue and the back
// frame engine. Depends on mfr_pkg, mfr_front and mfr_back.
//
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+----------------------
//   in       | input     | in_valid_i / in_stall_o | in_item_i  (in_item_t)
//   out      | output    | out_valid_o/out_stall_i | out_item_o (out_item_t)
//   cfg      | input     | cfg_valid_i/cfg_ready_o | cfg_data_i (timeout_ticks)
//
// One item per cycle sustained while the output is not stalled; an item
// passes first through the command queue, then the engine builds its result
// into the output register, from which the result is offered.
// The frame engine updates all state for one item when it takes that item.
// Reset clears frame state, the queue and the output slot; the timeout
// register returns to 1000. No clearing pass follows reset.
// A stalled output holds the engine; input stalls once the queue is full.
`default_nettype none

module meter_frame_receiver #(
  parameter int unsigned MAX_DATA_BYTES = mfr_pkg::MAX_DATA_BYTES_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire mfr_pkg::in_item_t  in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output mfr_pkg::out_item_t      out_item_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [31:0]        cfg_data_i
);

  logic          cmd_valid;
  mfr_pkg::cmd_t cmd;
  logic          cmd_pop;

  // Register writes are always taken
  assign cfg_ready_o = 1'b1;

  mfr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  mfr_back #(
    .MAX_DATA_BYTES (MAX_DATA_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire
